[src/im2col_pkg.sv]
`default_nettype none

package im2col_pkg;

  localparam int DEF_DIM_BITS   = 16;
  localparam int DEF_INDEX_BITS = 32;

  // APB: seven 32-bit registers at 4-byte spacing
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_SEL_BITS  = APB_ADDR_BITS - 2;

  typedef enum logic [REG_SEL_BITS-1:0] {
    REG_PLANE_COUNT = 3'd0,
    REG_INPUT_SIZE  = 3'd1,
    REG_OUTPUT_SIZE = 3'd2,
    REG_KERNEL_SIZE = 3'd3,
    REG_STRIDE      = 3'd4,
    REG_PADDING     = 3'd5,
    REG_DILATION    = 3'd6
  } reg_sel_t;

  localparam logic [15:0] RST_PLANE_COUNT = 16'd1;
  localparam logic [31:0] RST_HALVES_ONE  = 32'h0001_0001;
  localparam logic [31:0] RST_PADDING     = 32'h0000_0000;

  // controller -> datapath
  typedef struct packed {
    logic cnt_clear;
    logic cnt_step;
    logic do_mul;
    logic do_sum;
    logic do_clip;
    logic do_base;
    logic do_scale;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[src/im2col_regs.sv]
`default_nettype none

module im2col_regs #(
  parameter int DIM_BITS = im2col_pkg::DEF_DIM_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [im2col_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [im2col_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [im2col_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                       cfg_clear,
  output logic      [DIM_BITS-1:0]                   planes,
  output logic      [DIM_BITS-1:0]                   in_h,
  output logic      [DIM_BITS-1:0]                   in_w,
  output logic      [DIM_BITS-1:0]                   out_h,
  output logic      [DIM_BITS-1:0]                   out_w,
  output logic      [DIM_BITS-1:0]                   k_h,
  output logic      [DIM_BITS-1:0]                   k_w,
  output logic      [DIM_BITS-1:0]                   str_v,
  output logic      [DIM_BITS-1:0]                   str_h,
  output logic      [DIM_BITS-1:0]                   pad_t,
  output logic      [DIM_BITS-1:0]                   pad_l,
  output logic      [DIM_BITS-1:0]                   dil_v,
  output logic      [DIM_BITS-1:0]                   dil_h
);
  import im2col_pkg::*;

  // bits of each 16-bit half that survive the dimension width
  localparam int HW = (DIM_BITS < 16) ? DIM_BITS : 16;

  logic [15:0] plane_count;
  logic [31:0] input_size;
  logic [31:0] output_size;
  logic [31:0] kernel_size;
  logic [31:0] stride;
  logic [31:0] padding;
  logic [31:0] dilation;

  logic                    wr;
  logic [REG_SEL_BITS-1:0] sel;

  assign wr  = psel && penable && pwrite;
  assign sel = paddr[APB_ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count <= RST_PLANE_COUNT;
      input_size  <= RST_HALVES_ONE;
      output_size <= RST_HALVES_ONE;
      kernel_size <= RST_HALVES_ONE;
      stride      <= RST_HALVES_ONE;
      padding     <= RST_PADDING;
      dilation    <= RST_HALVES_ONE;
    end else if (wr) begin
      case (reg_sel_t'(sel))
        REG_PLANE_COUNT: plane_count <= pwdata[15:0];
        REG_INPUT_SIZE:  input_size  <= pwdata;
        REG_OUTPUT_SIZE: output_size <= pwdata;
        REG_KERNEL_SIZE: kernel_size <= pwdata;
        REG_STRIDE:      stride      <= pwdata;
        REG_PADDING:     padding     <= pwdata;
        REG_DILATION:    dilation    <= pwdata;
        default: ;
      endcase
    end
  end

  // any write that lands on a real register restarts the pass
  always_comb begin
    cfg_clear = 1'b0;
    prdata    = '0;
    case (reg_sel_t'(sel))
      REG_PLANE_COUNT: begin
        cfg_clear = wr;
        prdata    = {16'd0, plane_count};
      end
      REG_INPUT_SIZE: begin
        cfg_clear = wr;
        prdata    = input_size;
      end
      REG_OUTPUT_SIZE: begin
        cfg_clear = wr;
        prdata    = output_size;
      end
      REG_KERNEL_SIZE: begin
        cfg_clear = wr;
        prdata    = kernel_size;
      end
      REG_STRIDE: begin
        cfg_clear = wr;
        prdata    = stride;
      end
      REG_PADDING: begin
        cfg_clear = wr;
        prdata    = padding;
      end
      REG_DILATION: begin
        cfg_clear = wr;
        prdata    = dilation;
      end
      default: begin
        cfg_clear = 1'b0;
        prdata    = '0;
      end
    endcase
  end

  assign planes = DIM_BITS'(plane_count[HW-1:0]);
  assign in_h   = DIM_BITS'(input_size[16+HW-1:16]);
  assign in_w   = DIM_BITS'(input_size[HW-1:0]);
  assign out_h  = DIM_BITS'(output_size[16+HW-1:16]);
  assign out_w  = DIM_BITS'(output_size[HW-1:0]);
  assign k_h    = DIM_BITS'(kernel_size[16+HW-1:16]);
  assign k_w    = DIM_BITS'(kernel_size[HW-1:0]);
  assign str_v  = DIM_BITS'(stride[16+HW-1:16]);
  assign str_h  = DIM_BITS'(stride[HW-1:0]);
  assign pad_t  = DIM_BITS'(padding[16+HW-1:16]);
  assign pad_l  = DIM_BITS'(padding[HW-1:0]);
  assign dil_v  = DIM_BITS'(dilation[16+HW-1:16]);
  assign dil_h  = DIM_BITS'(dilation[HW-1:0]);

endmodule

`default_nettype wire

[src/im2col_ctrl.sv]
`default_nettype none

module im2col_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire logic                   restart,
  output logic                        in_stall,
  input  wire im2col_pkg::dp_status_t status,
  output im2col_pkg::ctrl_cmd_t       cmd
);
  import im2col_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_CLIP,
    ST_BASE,
    ST_SCALE,
    ST_FINISH
  } state_t;

  state_t state;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          // empty pass: no move, stay here
          if (accept && !status.empty) state <= ST_MUL;
        end
        ST_MUL:   state <= ST_SUM;
        ST_SUM:   state <= ST_CLIP;
        ST_CLIP:  state <= ST_BASE;
        ST_BASE:  state <= ST_SCALE;
        ST_SCALE: state <= ST_FINISH;
        ST_FINISH: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.cnt_clear = accept && (restart || status.empty);
    cmd.cnt_step  = (state == ST_MUL);
    cmd.do_mul    = (state == ST_MUL);
    cmd.do_sum    = (state == ST_SUM);
    cmd.do_clip   = (state == ST_CLIP);
    cmd.do_base   = (state == ST_BASE);
    cmd.do_scale  = (state == ST_SCALE);
    cmd.load_out  = (state == ST_FINISH) && status.out_free;
  end

endmodule

`default_nettype wire

[src/im2col_datapath.sv]
`default_nettype none

module im2col_datapath #(
  parameter int DIM_BITS   = im2col_pkg::DEF_DIM_BITS,
  parameter int INDEX_BITS = im2col_pkg::DEF_INDEX_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire im2col_pkg::ctrl_cmd_t  cmd,
  output im2col_pkg::dp_status_t      status,
  input  wire logic                   cfg_clear,
  input  wire logic [DIM_BITS-1:0]    planes,
  input  wire logic [DIM_BITS-1:0]    in_h,
  input  wire logic [DIM_BITS-1:0]    in_w,
  input  wire logic [DIM_BITS-1:0]    out_h,
  input  wire logic [DIM_BITS-1:0]    out_w,
  input  wire logic [DIM_BITS-1:0]    k_h,
  input  wire logic [DIM_BITS-1:0]    k_w,
  input  wire logic [DIM_BITS-1:0]    str_v,
  input  wire logic [DIM_BITS-1:0]    str_h,
  input  wire logic [DIM_BITS-1:0]    pad_t,
  input  wire logic [DIM_BITS-1:0]    pad_l,
  input  wire logic [DIM_BITS-1:0]    dil_v,
  input  wire logic [DIM_BITS-1:0]    dil_h,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output logic [31:0]                 source_index,
  output logic [31:0]                 dest_index,
  output logic                        zero_fill,
  output logic                        last_move
);
  import im2col_pkg::*;

  localparam int D  = DIM_BITS;
  localparam int PW = 2 * DIM_BITS;
  localparam int SW = PW + 1;
  localparam int IW = INDEX_BITS;

  // position counters
  logic [D-1:0]  plane_ctr, krow_ctr, kcol_ctr, orow_ctr, ocol_ctr;
  logic [D-1:0]  plane_ctr_next, krow_ctr_next, kcol_ctr_next, orow_ctr_next, ocol_ctr_next;
  logic [IW-1:0] dest_ctr, dest_ctr_next;

  logic [D:0] plane_inc, krow_inc, kcol_inc, orow_inc, ocol_inc;
  logic       is_last;

  // stage registers
  logic [PW-1:0] prod_rs, prod_rk, prod_cs, prod_ck, plane_base;
  logic [IW-1:0] dest_hold;
  logic          last_hold;
  logic [SW-1:0] tap_row, tap_col;
  logic [SW-1:0] row_diff, col_diff;
  logic          row_in, col_in;
  logic [D-1:0]  row_ofs, col_ofs;
  logic          tap_ok;
  logic [IW-1:0] lin_base, lin_scaled, src_sum;

  assign status.empty = (planes == '0) || (out_h == '0) || (out_w == '0) ||
                        (k_h == '0) || (k_w == '0);
  assign status.out_free = !out_valid || !out_stall;

  assign plane_inc = {1'b0, plane_ctr} + 1'b1;
  assign krow_inc  = {1'b0, krow_ctr} + 1'b1;
  assign kcol_inc  = {1'b0, kcol_ctr} + 1'b1;
  assign orow_inc  = {1'b0, orow_ctr} + 1'b1;
  assign ocol_inc  = {1'b0, ocol_ctr} + 1'b1;

  assign is_last = (plane_inc >= {1'b0, planes}) && (krow_inc >= {1'b0, k_h}) &&
                   (kcol_inc >= {1'b0, k_w}) && (orow_inc >= {1'b0, out_h}) &&
                   (ocol_inc >= {1'b0, out_w});

  // odometer: out col innermost, plane outermost
  always_comb begin
    plane_ctr_next = plane_ctr;
    krow_ctr_next  = krow_ctr;
    kcol_ctr_next  = kcol_ctr;
    orow_ctr_next  = orow_ctr;
    ocol_ctr_next  = ocol_ctr;
    dest_ctr_next  = dest_ctr;
    if (cmd.cnt_clear || cfg_clear || (cmd.cnt_step && is_last)) begin
      plane_ctr_next = '0;
      krow_ctr_next  = '0;
      kcol_ctr_next  = '0;
      orow_ctr_next  = '0;
      ocol_ctr_next  = '0;
      dest_ctr_next  = '0;
    end else if (cmd.cnt_step) begin
      dest_ctr_next = dest_ctr + 1'b1;
      if (ocol_inc < {1'b0, out_w}) begin
        ocol_ctr_next = ocol_inc[D-1:0];
      end else begin
        ocol_ctr_next = '0;
        if (orow_inc < {1'b0, out_h}) begin
          orow_ctr_next = orow_inc[D-1:0];
        end else begin
          orow_ctr_next = '0;
          if (kcol_inc < {1'b0, k_w}) begin
            kcol_ctr_next = kcol_inc[D-1:0];
          end else begin
            kcol_ctr_next = '0;
            if (krow_inc < {1'b0, k_h}) begin
              krow_ctr_next = krow_inc[D-1:0];
            end else begin
              krow_ctr_next  = '0;
              plane_ctr_next = plane_inc[D-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_ctr <= '0;
      krow_ctr  <= '0;
      kcol_ctr  <= '0;
      orow_ctr  <= '0;
      ocol_ctr  <= '0;
      dest_ctr  <= '0;
    end else begin
      plane_ctr <= plane_ctr_next;
      krow_ctr  <= krow_ctr_next;
      kcol_ctr  <= kcol_ctr_next;
      orow_ctr  <= orow_ctr_next;
      ocol_ctr  <= ocol_ctr_next;
      dest_ctr  <= dest_ctr_next;
    end
  end

  assign row_diff = tap_row - SW'(pad_t);
  assign col_diff = tap_col - SW'(pad_l);
  assign row_in   = (tap_row >= SW'(pad_t)) && (row_diff < SW'(in_h));
  assign col_in   = (tap_col >= SW'(pad_l)) && (col_diff < SW'(in_w));
  assign src_sum  = lin_scaled + IW'(col_ofs);

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      prod_rs    <= PW'(orow_ctr) * PW'(str_v);
      prod_rk    <= PW'(krow_ctr) * PW'(dil_v);
      prod_cs    <= PW'(ocol_ctr) * PW'(str_h);
      prod_ck    <= PW'(kcol_ctr) * PW'(dil_h);
      plane_base <= PW'(plane_ctr) * PW'(in_h);
      dest_hold  <= dest_ctr;
      last_hold  <= is_last;
    end
    if (cmd.do_sum) begin
      tap_row <= SW'(prod_rs) + SW'(prod_rk);
      tap_col <= SW'(prod_cs) + SW'(prod_ck);
    end
    if (cmd.do_clip) begin
      row_ofs <= row_diff[D-1:0];
      col_ofs <= col_diff[D-1:0];
      tap_ok  <= row_in && col_in;
    end
    if (cmd.do_base) begin
      lin_base <= IW'(plane_base) + IW'(row_ofs);
    end
    if (cmd.do_scale) begin
      lin_scaled <= lin_base * IW'(in_w);
    end
    if (cmd.load_out) begin
      source_index <= tap_ok ? 32'(src_sum) : 32'd0;
      dest_index   <= 32'(dest_hold);
      zero_fill    <= !tap_ok;
      last_move    <= last_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[src/im2col_address_generator.sv]
`default_nettype none

// im2col address generator. Each accepted request (restart=1 starts a new
// pass, restart=0 advances) yields one element move for a copy engine, in
// the order plane, kernel row, kernel column, output row, output column.
// A move carries the input element index, the unfolded destination index, a
// zero-fill flag for taps in padding (source index then 0) and a flag on
// the final move of the pass, after which the position wraps to the start.
// If plane count or any kernel or output dimension is zero, the request is
// taken and no move comes out. Any write to a defined register puts the
// position back at the start; write only while no request is in flight.
// The sequencer walks a single move at a time through multiply, tap sum,
// clip, row base, row scale and load steps; the load step waits while the
// output register is stalled. The input side stalls while a move is in
// work, so a new request is not taken before the current move is loaded;
// a finished move waits in the output register without holding up the
// next request. No memories, no clearing pass.
// Registers (APB, 4-byte spacing): 0 plane_count, 1 input_size,
// 2 output_size, 3 kernel_size, 4 stride, 5 padding, 6 dilation; the
// two-dimension registers hold height/vertical in [31:16], width/horizontal
// in [15:0]. Index arithmetic wraps at INDEX_BITS.
module im2col_address_generator #(
  parameter int DIM_BITS   = im2col_pkg::DEF_DIM_BITS,
  parameter int INDEX_BITS = im2col_pkg::DEF_INDEX_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [im2col_pkg::APB_ADDR_BITS-1:0] paddr,
  input  wire logic [im2col_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic      [im2col_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                      pready,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 restart,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [31:0]                          source_index,
  output logic      [31:0]                          dest_index,
  output logic                                      zero_fill,
  output logic                                      last_move
);
  import im2col_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_clear;

  logic [DIM_BITS-1:0] planes, in_h, in_w, out_h, out_w, k_h, k_w;
  logic [DIM_BITS-1:0] str_v, str_h, pad_t, pad_l, dil_v, dil_h;

  // zero wait states
  assign pready = 1'b1;

  im2col_regs #(
    .DIM_BITS (DIM_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .cfg_clear (cfg_clear),
    .planes    (planes),
    .in_h      (in_h),
    .in_w      (in_w),
    .out_h     (out_h),
    .out_w     (out_w),
    .k_h       (k_h),
    .k_w       (k_w),
    .str_v     (str_v),
    .str_h     (str_h),
    .pad_t     (pad_t),
    .pad_l     (pad_l),
    .dil_v     (dil_v),
    .dil_h     (dil_h)
  );

  // sequencer: one move at a time
  im2col_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .restart  (restart),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // counters, tap arithmetic and the output register
  im2col_datapath #(
    .DIM_BITS   (DIM_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_clear    (cfg_clear),
    .planes       (planes),
    .in_h         (in_h),
    .in_w         (in_w),
    .out_h        (out_h),
    .out_w        (out_w),
    .k_h          (k_h),
    .k_w          (k_w),
    .str_v        (str_v),
    .str_h        (str_h),
    .pad_t        (pad_t),
    .pad_l        (pad_l),
    .dil_v        (dil_v),
    .dil_h        (dil_h),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .source_index (source_index),
    .dest_index   (dest_index),
    .zero_fill    (zero_fill),
    .last_move    (last_move)
  );

endmodule

`default_nettype wire

[src/im2col_checker.sv]
`default_nettype none

module im2col_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] source_index,
  input wire logic [31:0] dest_index,
  input wire logic        zero_fill,
  input wire logic        last_move
);

  // padded taps never carry an address
  a_zero_src: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_fill |-> source_index == 32'd0)
    else $error("zero-fill move with non-zero source index");

  // output register empty straight after reset
  a_rst_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // a move only completes while the input side is busy with it
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no transaction in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(source_index) &&
      $stable(dest_index) && $stable(zero_fill) && $stable(last_move))
    else $error("stalled result changed");

endmodule

bind im2col_address_generator im2col_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .source_index (source_index),
  .dest_index   (dest_index),
  .zero_fill    (zero_fill),
  .last_move    (last_move)
);

`default_nettype wire

[tb/sv/im2col_address_generator_tb.sv]
`timescale 1ns / 100ps

// Unfold address generator bench: random request stream against a
// transaction-level predictor of the element walk.
module im2col_address_generator_tb;
  import im2col_pkg::*;

  // Nothing is decoded at this register slot; a write there must leave the
  // walk where it is.
  localparam logic [REG_SEL_BITS-1:0] REG_UNUSED = 3'd7;
  // Cycles allowed after the last move for a request that makes no move.
  localparam int LATENCY_PAD = 16;
  localparam int RANDOM_REQUESTS = 850;
  // Move count at which the receiver starts its long hold-off.
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 150;

  typedef struct {
    logic [31:0] src;
    logic [31:0] dst;
    logic        zf;
    logic        last;
  } move_t;

  // Mirror of the configuration and of the walk position. note_request works
  // out the move a request produces; check_move pairs each move seen at the
  // output with the oldest one still waiting.
  class unfold_walk_scoreboard;
    logic [15:0] planes;
    logic [31:0] in_size, out_size, k_size, strd, pad, dil;
    bit [63:0]   plane_n, krow, kcol, orow, ocol;
    bit [31:0]   dest_n;
    move_t       moves[$];
    int          errors;

    function new();
      planes   = RST_PLANE_COUNT;
      in_size  = RST_HALVES_ONE;
      out_size = RST_HALVES_ONE;
      k_size   = RST_HALVES_ONE;
      strd     = RST_HALVES_ONE;
      pad      = RST_PADDING;
      dil      = RST_HALVES_ONE;
      errors   = 0;
      rewind();
    endfunction

    function void rewind();
      plane_n = 0;
      krow    = 0;
      kcol    = 0;
      orow    = 0;
      ocol    = 0;
      dest_n  = 0;
    endfunction

    function void write_reg(logic [REG_SEL_BITS-1:0] sel, logic [31:0] value);
      case (sel)
        REG_PLANE_COUNT: planes = value[15:0];
        REG_INPUT_SIZE:  in_size = value;
        REG_OUTPUT_SIZE: out_size = value;
        REG_KERNEL_SIZE: k_size = value;
        REG_STRIDE:      strd = value;
        REG_PADDING:     pad = value;
        REG_DILATION:    dil = value;
        default:         return;
      endcase
      rewind();
    endfunction

    // One axis of the tap: inside when out*stride + k*dilation - pad lands
    // in [0, size).
    function bit tap_inside(bit [63:0] o, bit [63:0] s, bit [63:0] k, bit [63:0] d,
                            bit [63:0] p, bit [63:0] size, output bit [63:0] pos);
      bit [63:0] a;
      pos = 0;
      a = o * s + k * d;
      if (a < p) return 0;
      a = a - p;
      if (a >= size) return 0;
      pos = a;
      return 1;
    endfunction

    function void note_request(bit restart);
      move_t     m;
      bit [63:0] row, col, idx;
      bit        in_r, in_c, last;
      if (restart) rewind();
      // empty pass: no move at all, position parked at the start
      if (planes == 0 || out_size[31:16] == 0 || out_size[15:0] == 0 ||
          k_size[31:16] == 0 || k_size[15:0] == 0) begin
        rewind();
        return;
      end
      in_r = tap_inside(orow, strd[31:16], krow, dil[31:16], pad[31:16],
                        in_size[31:16], row);
      in_c = tap_inside(ocol, strd[15:0], kcol, dil[15:0], pad[15:0],
                        in_size[15:0], col);
      idx = (plane_n * in_size[31:16] + row) * in_size[15:0] + col;
      m.src  = (in_r && in_c) ? idx[31:0] : 32'd0;
      m.dst  = dest_n;
      m.zf   = !(in_r && in_c);
      last   = (plane_n + 1 >= planes) && (krow + 1 >= k_size[31:16]) &&
               (kcol + 1 >= k_size[15:0]) && (orow + 1 >= out_size[31:16]) &&
               (ocol + 1 >= out_size[15:0]);
      m.last = last;
      moves.push_back(m);
      if (last) begin
        rewind();
        return;
      end
      // innermost first: out column, out row, kernel column, kernel row, plane
      dest_n = dest_n + 1;
      ocol++;
      if (ocol < out_size[15:0]) return;
      ocol = 0;
      orow++;
      if (orow < out_size[31:16]) return;
      orow = 0;
      kcol++;
      if (kcol < k_size[15:0]) return;
      kcol = 0;
      krow++;
      if (krow < k_size[31:16]) return;
      krow = 0;
      plane_n = (plane_n + 1) & 64'hFFFF;
    endfunction

    function void check_move(logic [31:0] src, logic [31:0] dst, logic zf, logic last);
      move_t m;
      if (moves.size() == 0) begin
        $error("unexpected move: source_index %0d dest_index %0d", src, dst);
        errors++;
        return;
      end
      m = moves.pop_front();
      if (src !== m.src) begin
        $error("source_index: expected %0d, got %0d", m.src, src);
        errors++;
      end
      if (dst !== m.dst) begin
        $error("dest_index: expected %0d, got %0d", m.dst, dst);
        errors++;
      end
      if (zf !== m.zf) begin
        $error("zero_fill: expected %0b, got %0b", m.zf, zf);
        errors++;
      end
      if (last !== m.last) begin
        $error("last_move: expected %0b, got %0b", m.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return moves.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     psel, penable, pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  logic                     in_valid, in_stall, restart;
  logic                     out_valid, out_stall;
  logic [31:0]              source_index, dest_index;
  logic                     zero_fill, last_move;

  unfold_walk_scoreboard sb = new();

  // Shared pacing flags: quiet turns off random idling on both sides.
  bit quiet = 1'b0;
  int moves_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  im2col_address_generator uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .source_index (source_index),
    .dest_index   (dest_index),
    .zero_fill    (zero_fill),
    .last_move    (last_move)
  );

  always #5 clk = ~clk;

  // Result side: every move taken is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_move(source_index, dest_index, zero_fill, last_move);
      moves_seen++;
    end
  end

  // Result side stall. Once, after enough moves and while a request is on
  // offer, the receiver holds off for a long stretch so the output register
  // fills and the block stalls requests.
  always @(negedge clk) begin
    if (!hold_done && moves_seen >= HOLD_AFTER && in_valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 9);
    end
  end

  // Entered and left at a falling edge. Random idle cycles go before the
  // request; the request is held until the block takes it. in_valid is left
  // high so back-to-back requests need no second assignment in one step.
  task automatic send_request(input bit rs);
    if (!quiet) begin
      while ($urandom_range(99) < 9) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
    sb.note_request(rs);
    @(negedge clk);
  endtask

  // Drain: no request offered, every predicted move back, then room for a
  // request that made no move to finish before registers are touched.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
    @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, bus released before returning.
  task automatic apb_write(input logic [REG_SEL_BITS-1:0] sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(sel, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly small shapes so passes end often; now and then an empty shape,
  // now and then full-width geometry where nearly every tap is padding.
  task automatic program_random();
    logic [15:0] pl, oh, ow, kh, kw;
    logic [31:0] in_w, st, pd, dl;
    int          shape;
    bit          wide;
    shape = $urandom_range(19);
    wide  = ($urandom_range(7) == 0);
    pl = 16'($urandom_range(1, 3));
    oh = 16'($urandom_range(1, 3));
    ow = 16'($urandom_range(1, 3));
    kh = 16'($urandom_range(1, 3));
    kw = 16'($urandom_range(1, 3));
    case (shape)
      0: pl = 16'd0;
      1: oh = 16'd0;
      2: kw = 16'd0;
      default: ;
    endcase
    if (wide) begin
      in_w = $urandom;
      st   = $urandom;
      pd   = $urandom;
      dl   = $urandom;
    end else begin
      in_w = {16'($urandom_range(0, 6)), 16'($urandom_range(0, 6))};
      st   = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))};
      pd   = {16'($urandom_range(0, 2)), 16'($urandom_range(0, 2))};
      dl   = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))};
    end
    // upper half of the plane count register is ignored by the block
    apb_write(REG_PLANE_COUNT, {16'($urandom), pl});
    apb_write(REG_INPUT_SIZE, in_w);
    apb_write(REG_OUTPUT_SIZE, {oh, ow});
    apb_write(REG_KERNEL_SIZE, {kh, kw});
    apb_write(REG_STRIDE, st);
    apb_write(REG_PADDING, pd);
    apb_write(REG_DILATION, dl);
  endtask

  initial begin
    int i;
    int n_items;
    int burst;
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    restart   = 1'b0;
    out_stall = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset geometry is 1x1 everywhere: every move is a whole pass.
    send_request(1'b0);
    send_request(1'b1);
    settle();

    // Two planes, 3x3 input with a border of padding, 2x2 kernel and output,
    // stride 2: mixes real taps and zero-fill; restart lands mid-pass.
    apb_write(REG_PLANE_COUNT, 32'hABCD_0002);
    apb_write(REG_INPUT_SIZE, 32'h0003_0003);
    apb_write(REG_OUTPUT_SIZE, 32'h0002_0002);
    apb_write(REG_KERNEL_SIZE, 32'h0002_0002);
    apb_write(REG_STRIDE, 32'h0002_0002);
    apb_write(REG_PADDING, 32'h0001_0001);
    apb_write(REG_DILATION, 32'h0001_0001);
    for (i = 0; i < 8; i++) send_request(i == 5);
    settle();

    // Zero kernel height: requests are taken but no move comes out.
    apb_write(REG_KERNEL_SIZE, 32'h0000_0002);
    send_request(1'b0);
    send_request(1'b1);
    settle();

    // Every field at its maximum with a 1x1 walk: each move is a new plane,
    // so the source index climbs in steps of 65535*65535 and wraps.
    apb_write(REG_PLANE_COUNT, 32'hFFFF_FFFF);
    apb_write(REG_INPUT_SIZE, 32'hFFFF_FFFF);
    apb_write(REG_OUTPUT_SIZE, 32'h0001_0001);
    apb_write(REG_KERNEL_SIZE, 32'h0001_0001);
    apb_write(REG_STRIDE, 32'hFFFF_FFFF);
    apb_write(REG_PADDING, 32'h0000_0000);
    apb_write(REG_DILATION, 32'hFFFF_FFFF);
    for (i = 0; i < 5; i++) send_request(1'b0);
    settle();
    // undecoded slot: the plane walk must carry on from where it was
    apb_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_request(1'b0);
    send_request(1'b0);
    settle();

    // Padding at its maximum: every tap falls in padding.
    apb_write(REG_PADDING, 32'hFFFF_FFFF);
    send_request(1'b0);
    send_request(1'b0);
    settle();

    // Random part: bursts of advances with the odd restart, usually under a
    // fresh geometry; one stretch with no idling on either side.
    n_items = 0;
    while (n_items < RANDOM_REQUESTS) begin
      if ($urandom_range(3) != 0) program_random();
      burst = $urandom_range(15, 50);
      repeat (burst) begin
        quiet <= (n_items >= 400 && n_items < 550);
        send_request($urandom_range(99) < 5);
        n_items++;
      end
      settle();
    end

    quiet <= 1'b0;
    repeat (LATENCY_PAD) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("im2col_address_generator regression: pass");
    end else begin
      $display("im2col_address_generator regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("im2col_address_generator regression: fail");
    $finish;
  end

endmodule

[im2col_address_generator.f]
src/im2col_pkg.sv
src/im2col_regs.sv
src/im2col_ctrl.sv
src/im2col_datapath.sv
src/im2col_address_generator.sv
src/im2col_checker.sv
tb/sv/im2col_address_generator_tb.sv
